// ===== src/dra_pkg.sv =====
// Package for the decayed return accumulator.
// Holds fixed widths, fixed-point constants and the fractional power-of-two table.
// No dependencies.
package dra_pkg;

	// Fixed field and state widths
	localparam int ACC_W  = 40;   // accumulator, signed Q16.24
	localparam int TIME_W = 48;   // millisecond timestamps
	localparam int TAU_W  = 32;   // time constant in ms
	localparam int RET_W  = 32;   // relative return, signed Q8.24

	localparam logic [TAU_W-1:0] TAU_RESET = 32'd1000;

	// Serial division lengths: return quotient < 2^31, dt/tau quotient <= 2^20
	localparam int RET_QW = 31;
	localparam int DEC_QW = 21;

	// Decay arithmetic, Q1.16
	localparam int Q16_W = 17;
	localparam logic [Q16_W-1:0] ONE_Q16   = 17'h1_0000;
	localparam logic [Q16_W-1:0] LOG2E_Q16 = 17'd94548;
	localparam int Y_W = 22;      // dt/tau * log2(e), Q6.16
	localparam int MUL_STEPS = Q16_W;

	// Saturation bounds
	localparam logic [RET_W-1:0] RET_MAX = 32'h7FFF_FFFF;
	localparam logic [RET_W-1:0] RET_MIN = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ACC_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [ACC_W-1:0] ACC_MIN = 40'h80_0000_0000;

	// round(2^(-2^-(k+1)) * 2^16), k = 0 is the most significant fraction bit
	function automatic logic [15:0] frac_pow(input logic [3:0] k);
		logic [15:0] v;
		case (k)
			4'd0:    v = 16'd46341;
			4'd1:    v = 16'd55109;
			4'd2:    v = 16'd60097;
			4'd3:    v = 16'd62757;
			4'd4:    v = 16'd64132;
			4'd5:    v = 16'd64830;
			4'd6:    v = 16'd65182;
			4'd7:    v = 16'd65359;
			4'd8:    v = 16'd65447;
			4'd9:    v = 16'd65492;
			4'd10:   v = 16'd65514;
			4'd11:   v = 16'd65525;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/dra_if.sv =====
// Valid/ready channel interfaces for the accumulator's sample and result streams.
// Depends on dra_pkg for the fixed field widths.
interface dra_in_if import dra_pkg::*; #(parameter int PRICE_BITS = 32);
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [PRICE_BITS-1:0] mid_price;
	logic [TIME_W-1:0]        timestamp_ms;
	logic                     valid_flag;
	logic                     source_valid;

	modport source (output valid, operation, mid_price, timestamp_ms, valid_flag,
		source_valid, input ready);
	modport sink (input valid, operation, mid_price, timestamp_ms, valid_flag,
		source_valid, output ready);
endinterface

interface dra_out_if import dra_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] signal_value;
	logic                    signal_valid;
	logic                    value_written;

	modport source (output valid, signal_value, signal_valid, value_written, input ready);
	modport sink (input valid, signal_value, signal_valid, value_written, output ready);
endinterface

// ===== src/dra_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Caller supplies the upper remainder (must be below the divisor) and the low
// numerator bits. No package dependencies.
module dra_sdiv #(
	parameter int DW = 32,
	parameter int QW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] init_rem,
	input  logic [QW-1:0] feed,
	input  logic [DW-1:0] dvsr,
	output logic          busy,
	output logic [QW-1:0] quot
);
	localparam int CW = $clog2(QW);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] num_q;     // numerator bits out at the top, quotient bits in at the bottom
	logic [DW-1:0] dvsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// One restoring step
	assign trial = {rem_q, num_q[QW-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = (trial >= {1'b0, dvsr_q});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= init_rem;
			num_q  <= feed;
			dvsr_q <= dvsr;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

// ===== src/decayed_return_accumulator_top.sv =====
// Decayed return accumulator: one result per accepted transaction.
// Price sample that accumulates: the dt/tau and return divisions start together; after
// the dt/tau division, one power-of-two step per fraction bit and a shift-add scaling
// precede the sum. Other transactions go straight to the output stage. A transaction is
// accepted only in idle, so never before the previous result is in the output register.
// Asynchronous active-low reset clears control and architectural state; tau resets to 1000 ms.
module decayed_return_accumulator_top import dra_pkg::*; #(
	parameter int PRICE_BITS     = 32,
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TAU_W-1:0] cfg_wdata,
	dra_in_if.sink           sample,
	dra_out_if.source        result
);
	localparam int CNT_W = $clog2(MUL_STEPS);
	localparam int ETB   = EXP_TABLE_BITS;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_PREP = 11'b000_0000_0010,
		S_ABS  = 11'b000_0000_0100,
		S_KICK = 11'b000_0000_1000,
		S_DIV  = 11'b000_0001_0000,
		S_LOG  = 11'b000_0010_0000,
		S_EXP  = 11'b000_0100_0000,
		S_FIN  = 11'b000_1000_0000,
		S_MUL  = 11'b001_0000_0000,
		S_SUM  = 11'b010_0000_0000,
		S_OUT  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Architectural state
	logic signed [PRICE_BITS-1:0] prev_price_q;
	logic [TIME_W-1:0]            prev_time_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic                         ovalid_q;
	logic [TAU_W-1:0]             tau_q;
	logic                         written_q;

	// Latched transaction
	logic                         op_q;
	logic signed [PRICE_BITS-1:0] price_q;
	logic [TIME_W-1:0]            now_q;
	logic                         vflag_q;
	logic                         svalid_q;

	// Datapath registers
	logic signed [PRICE_BITS:0] diff_q;
	logic [TIME_W:0]            dtr_q;
	logic [PRICE_BITS-1:0]      od_q;
	logic [PRICE_BITS-1:0]      ad_q;
	logic [TIME_W-1:0]          dt_q;
	logic                       rsat_q;
	logic                       dzero_q;
	logic                       dbig_q;
	logic [Y_W-17:0]            yn_q;
	logic [15:0]                frac_q;
	logic [Q16_W-1:0]           m_q;
	logic [Q16_W-1:0]           dsh_q;
	logic [ACC_W-1:0]           amag_q;
	logic [ACC_W+Q16_W-1:0]     prod_q;
	logic [CNT_W-1:0]           cnt_q;

	// Output register
	logic                    res_vld_q;
	logic signed [ACC_W-1:0] res_val_q;
	logic                    res_sv_q;
	logic                    res_wr_q;

	logic accept;
	logic out_load;
	logic simple;

	logic                  rdiv_busy;
	logic [RET_QW-1:0]     rdiv_quot;
	logic                  ddiv_busy;
	logic [DEC_QW-1:0]     ddiv_quot;
	logic                  div_start;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign out_load     = (state_q == S_OUT) && (!res_vld_q || result.ready);
	assign simple       = op_q || (prev_price_q == '0);
	assign div_start    = (state_q == S_KICK);

	// Return division: (|diff| << 24) / |old|, 31 quotient bits
	dra_sdiv #(.DW(PRICE_BITS), .QW(RET_QW)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem ({7'b0, ad_q[PRICE_BITS-1:7]}),
		.feed     ({ad_q[6:0], 24'b0}),
		.dvsr     (od_q),
		.busy     (rdiv_busy),
		.quot     (rdiv_quot)
	);

	// Decay division: (dt << 16) / tau, 21 quotient bits
	dra_sdiv #(.DW(TAU_W), .QW(DEC_QW)) u_ddiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem (dt_q[TAU_W+4:5]),
		.feed     ({dt_q[4:0], 16'b0}),
		.dvsr     (tau_q),
		.busy     (ddiv_busy),
		.quot     (ddiv_quot)
	);

	// Combinational helpers
	logic [DEC_QW+Q16_W-1:0] prod_y;
	logic [Y_W-1:0]          y_full;
	logic [2*16:0]           m_prod;
	logic [2*16+1:0]         m_round;
	logic [Q16_W-1:0]        m_next;
	logic [Q16_W-1:0]        decay;
	logic [ACC_W:0]          pm;
	logic signed [ACC_W+1:0] spm;
	logic [RET_W-1:0]        ret;
	logic signed [ACC_W+1:0] sum;
	logic [ACC_W-1:0]        sum_sat;

	// dt/tau scaled to base two
	assign prod_y = ddiv_quot * LOG2E_Q16;
	assign y_full = prod_y[DEC_QW+Q16_W-1:16];

	// One fractional power-of-two step, rounded
	assign m_prod  = m_q * frac_pow(cnt_q[3:0]);
	assign m_round = {1'b0, m_prod} + 34'd32768;
	assign m_next  = m_round[32:16];

	// Final decay factor
	always_comb begin
		if (dzero_q) begin
			decay = ONE_Q16;
		end else if (dbig_q || (yn_q > 6'd16)) begin
			decay = '0;
		end else begin
			decay = m_q >> yn_q[4:0];
		end
	end

	// Decayed magnitude back to signed, plus the saturated return
	assign pm  = prod_q[ACC_W+Q16_W-1:16];
	assign spm = acc_q[ACC_W-1] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});

	always_comb begin
		if (rsat_q) begin
			ret = diff_q[PRICE_BITS] ? RET_MIN : RET_MAX;
		end else if (diff_q[PRICE_BITS]) begin
			ret = RET_W'(-{1'b0, rdiv_quot});
		end else begin
			ret = {1'b0, rdiv_quot};
		end
	end

	assign sum = spm + {{(ACC_W+2-RET_W){ret[RET_W-1]}}, ret};

	always_comb begin
		if (!sum[ACC_W+1] && (sum[ACC_W:ACC_W-1] != 2'b00)) begin
			sum_sat = ACC_MAX;
		end else if (sum[ACC_W+1] && (sum[ACC_W:ACC_W-1] != 2'b11)) begin
			sum_sat = ACC_MIN;
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_price_q <= '0;
			prev_time_q  <= '0;
			acc_q        <= '0;
			ovalid_q     <= 1'b0;
			tau_q        <= TAU_RESET;
			written_q    <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				tau_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					written_q <= 1'b0;
					if (simple) begin
						state_q <= S_OUT;
						if (!op_q) begin
							// no previous price held (stored price is zero): store only
							prev_price_q <= price_q;
							prev_time_q  <= now_q;
						end else if (!vflag_q) begin
							prev_price_q <= '0;
							prev_time_q  <= '0;
							acc_q        <= '0;
							ovalid_q     <= 1'b0;
						end else if (svalid_q) begin
							prev_price_q <= price_q;
							prev_time_q  <= now_q;
							ovalid_q     <= 1'b1;
						end
					end else begin
						state_q <= S_ABS;
					end
				end
				S_ABS:  state_q <= S_KICK;
				S_KICK: state_q <= S_DIV;
				S_DIV: begin
					if (!ddiv_busy) begin
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					cnt_q   <= '0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					if (cnt_q == CNT_W'(ETB - 1)) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						state_q <= S_SUM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SUM: begin
					acc_q        <= sum_sat;
					prev_price_q <= price_q;
					prev_time_q  <= now_q;
					written_q    <= 1'b1;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= sample.operation;
			price_q  <= sample.mid_price;
			now_q    <= sample.timestamp_ms;
			vflag_q  <= sample.valid_flag;
			svalid_q <= sample.source_valid;
		end
		case (state_q)
			S_PREP: begin
				diff_q <= {price_q[PRICE_BITS-1], price_q}
					- {prev_price_q[PRICE_BITS-1], prev_price_q};
				dtr_q  <= {1'b0, now_q} - {1'b0, prev_time_q};
				od_q   <= prev_price_q[PRICE_BITS-1]
					? PRICE_BITS'(-prev_price_q) : prev_price_q;
			end
			S_ABS: begin
				ad_q <= diff_q[PRICE_BITS] ? PRICE_BITS'(-diff_q) : diff_q[PRICE_BITS-1:0];
				// time going backwards counts as no elapsed time
				dt_q <= dtr_q[TIME_W] ? '0 : dtr_q[TIME_W-1:0];
			end
			S_KICK: begin
				rsat_q  <= ({7'b0, ad_q} >= {od_q, 7'b0});
				dzero_q <= (dt_q == '0);
				dbig_q  <= (dt_q > {{(TIME_W-TAU_W-4){1'b0}}, tau_q, 4'b0});
			end
			S_LOG: begin
				yn_q   <= y_full[Y_W-1:16];
				frac_q <= y_full[15:0];
				m_q    <= ONE_Q16;
			end
			S_EXP: begin
				if (frac_q[15]) begin
					m_q <= m_next;
				end
				frac_q <= {frac_q[14:0], 1'b0};
			end
			S_FIN: begin
				dsh_q  <= decay;
				amag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
				prod_q <= '0;
			end
			S_MUL: begin
				// shift-add, decay factor MSB first
				prod_q <= {prod_q[ACC_W+Q16_W-2:0], 1'b0}
					+ (dsh_q[Q16_W-1] ? {{Q16_W{1'b0}}, amag_q} : '0);
				dsh_q  <= {dsh_q[Q16_W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_load) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_val_q <= acc_q;
			res_sv_q  <= ovalid_q;
			res_wr_q  <= written_q;
		end
	end

	assign result.valid         = res_vld_q;
	assign result.signal_value  = res_val_q;
	assign result.signal_valid  = res_sv_q;
	assign result.value_written = res_wr_q;

	// Checks
	a_ret_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> !rdiv_busy)
		else $error("return division still running at accumulation");

	a_idle_dividers: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> (!rdiv_busy && !ddiv_busy))
		else $error("transaction taken while a divider is busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && res_vld_q && !result.ready) |=> (state_q == S_OUT))
		else $error("result left while output register full");

	a_decay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP) |-> (m_q <= ONE_Q16))
		else $error("decay factor above one");

endmodule

// ===== tb/decayed_return_accumulator_top_test.sv =====
// Self-checking testbench for the decayed return accumulator top level.
// Drives price and validity transactions, predicts each result with a shadow model.
// Depends on dra_pkg, dra_if and decayed_return_accumulator_top.
`timescale 1ns / 100ps

module decayed_return_accumulator_top_test;
	import dra_pkg::*;

	localparam int PRICE_W       = 32;
	localparam int FRAC_BITS     = 8;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_MAX      = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int SETTLE_CYCLES = 60;
	localparam int PUMP_PAIRS    = 100;
	localparam int RUN_LIMIT_NS  = 5_000_000;

	localparam logic OP_PRICE    = 1'b0;
	localparam logic OP_VALIDITY = 1'b1;

	localparam logic [63:0] MASK48     = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] UNITY_Q16  = 64'd65536;
	localparam logic [63:0] LOG2E_FIX  = 64'd94548;
	localparam longint      RET_TOP    = 64'sd2147483647;
	localparam longint      RET_BOTTOM = -64'sd2147483648;
	localparam longint      ACC_TOP    = 64'sd549755813887;
	localparam longint      ACC_BOTTOM = -64'sd549755813888;

	// 2^(-2^-(k+1)) in Q16, most significant fraction bit first
	localparam logic [0:7][15:0] POW2_FRAC_Q16 = {16'd46341, 16'd55109, 16'd60097,
		16'd62757, 16'd64132, 16'd64830, 16'd65182, 16'd65359};

	typedef struct packed {
		logic                      operation;
		logic signed [PRICE_W-1:0] mid_price;
		logic [TIME_W-1:0]         timestamp_ms;
		logic                      valid_flag;
		logic                      source_valid;
	} tick_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] signal_value;
		logic                    signal_valid;
		logic                    value_written;
	} signal_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [TAU_W-1:0] cfg_wdata;

	dra_in_if #(.PRICE_BITS(PRICE_W)) sample_ch ();
	dra_out_if                        result_ch ();

	decayed_return_accumulator_top #(
		.PRICE_BITS    (PRICE_W),
		.EXP_TABLE_BITS(FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	// Shadow state of the accumulator
	longint           held_price;
	logic [TIME_W-1:0] held_time;
	longint           acc_q24;
	bit               acc_valid;
	logic [TAU_W-1:0] tau_ms;

	tick_t   tick_queue[$];
	signal_t awaited_signal[$];
	tick_t   next_tick, bus_tick;
	signal_t predicted, got, want;

	int fault_count;
	int ticks_queued;
	bit tick_taken, signal_taken, tick_on_bus;
	int send_gap, recv_stall;
	bit send_burst, recv_burst;

	// Stimulus generator's running price and time
	longint      gen_price;
	logic [63:0] gen_ts;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Relative return (fresh - prior) / |prior| in Q8.24, truncated magnitude
	function automatic longint return_q24(longint fresh, longint prior);
		longint      diff;
		logic [63:0] ad, od, mag;
		diff = fresh - prior;
		ad = (diff < 0) ? -diff : diff;
		od = (prior < 0) ? -prior : prior;
		if (od == 0)
			return 0;
		if (ad >= (od << 7))
			return (diff < 0) ? RET_BOTTOM : RET_TOP;
		mag = (ad << 24) / od;
		return (diff < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// exp(-dt/tau) in Q1.16 via log2(e), integer shift and fraction table
	function automatic logic [63:0] decay_q16(logic [63:0] dt, logic [63:0] tau);
		logic [63:0] x, y, n, f, m;
		if (dt == 0)
			return UNITY_Q16;
		if (dt > (tau << 4))
			return 0;
		x = (dt << 16) / tau;
		y = (x * LOG2E_FIX) >> 16;
		n = y >> 16;
		f = y[15:0] >> (16 - FRAC_BITS);
		m = UNITY_Q16;
		for (int k = 0; k < FRAC_BITS; k++)
			if (f[FRAC_BITS-1-k])
				m = (m * POW2_FRAC_Q16[k] + 64'd32768) >> 16;
		if (n > 16)
			return 0;
		return m >> n;
	endfunction

	// Advance the shadow state by one transaction and form its result
	task automatic step_shadow(input tick_t t, output signal_t s);
		longint      price, ret, sum;
		logic [63:0] now, dt, d, amag, pm;
		bit          written;
		price = longint'($signed(t.mid_price));
		now = t.timestamp_ms;
		written = 1'b0;
		if (t.operation == OP_PRICE) begin
			if (held_price == 0) begin
				held_price = price;
				held_time = now[TIME_W-1:0];
			end else begin
				ret = return_q24(price, held_price);
				dt = (now >= held_time) ? now - held_time : 64'd0;
				d = decay_q16(dt, tau_ms);
				amag = (acc_q24 < 0) ? -acc_q24 : acc_q24;
				pm = (amag * d) >> 16;
				sum = ((acc_q24 < 0) ? -longint'(pm) : longint'(pm)) + ret;
				if (sum > ACC_TOP)
					sum = ACC_TOP;
				if (sum < ACC_BOTTOM)
					sum = ACC_BOTTOM;
				acc_q24 = sum;
				held_price = price;
				held_time = now[TIME_W-1:0];
				written = 1'b1;
			end
		end else if (!t.valid_flag) begin
			held_price = 0;
			held_time = '0;
			acc_q24 = 0;
			acc_valid = 1'b0;
		end else if (t.source_valid) begin
			held_price = price;
			held_time = now[TIME_W-1:0];
			acc_valid = 1'b1;
		end
		s.signal_value = acc_q24[ACC_W-1:0];
		s.signal_valid = acc_valid;
		s.value_written = written;
	endtask

	function automatic int idle_cycles(bit burst);
		return burst ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Elapsed time spread around the decay thresholds of the current tau
	function automatic logic [63:0] pick_dt(logic [63:0] tau);
		logic [63:0] span;
		span = tau << 4;
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 1;
			2, 3, 4: return rand64() % (tau + 1);
			5, 6:    return rand64() % (span + 1);
			7:       return span;
			8:       return span + 1;
			default: return rand64() & MASK48;
		endcase
	endfunction

	// Mostly a nearby price, sometimes a wild one
	function automatic longint pick_price(longint p);
		longint v, reach;
		case ($urandom_range(0, 9))
			0: v = longint'($signed($urandom));
			1: begin
				v = longint'($urandom_range(1, 200));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				reach = ((p < 0) ? -p : p) >> $urandom_range(1, 12);
				v = p - reach + longint'($urandom_range(0, 2 * reach));
				if (v == p)
					v = p + 1;
			end
		endcase
		if (v > RET_TOP)
			v = RET_TOP;
		if (v < RET_BOTTOM)
			v = RET_BOTTOM;
		return v;
	endfunction

	task automatic push_tick(logic op, longint price, logic [63:0] ts, logic vf, logic sv);
		tick_t t;
		t.operation = op;
		t.mid_price = price[PRICE_W-1:0];
		t.timestamp_ms = ts[TIME_W-1:0];
		t.valid_flag = vf;
		t.source_valid = sv;
		tick_queue.push_back(t);
		ticks_queued++;
	endtask

	// Hold until nothing is queued, on the bus or awaited
	task automatic drain();
		@(posedge clk);
		while (tick_queue.size() != 0 || sample_ch.valid || awaited_signal.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tau(logic [TAU_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		tau_ms = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reload-then-sample runs with random content, plus clears and noise
	task automatic random_phase(int count);
		int stop, run, sel;
		stop = ticks_queued + count;
		while (ticks_queued < stop) begin
			sel = $urandom_range(0, 19);
			if (sel < 13) begin
				if ($urandom_range(0, 1))
					gen_ts = rand64() & MASK48;
				gen_price = $urandom_range(0, 1) ? longint'($signed($urandom)) :
					longint'($urandom_range(1, 100000));
				push_tick(OP_VALIDITY, gen_price, gen_ts, 1'b1, 1'b1);
				run = $urandom_range(3, 10);
				repeat (run) begin
					sel = $urandom_range(0, 99);
					gen_price = (sel < 4) ? 0 : pick_price(gen_price);
					if (sel >= 4 && sel < 9)
						gen_ts = (gen_ts - $urandom_range(1, 5000)) & MASK48;
					else
						gen_ts = (gen_ts + pick_dt(tau_ms)) & MASK48;
					push_tick(OP_PRICE, gen_price, gen_ts, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
			end else if (sel < 15) begin
				push_tick(OP_VALIDITY, longint'($signed($urandom)), rand64(), 1'b0,
					1'($urandom_range(0, 1)));
			end else if (sel == 15) begin
				push_tick(OP_VALIDITY, longint'($signed($urandom)), rand64(), 1'b1, 1'b0);
			end else if (sel < 18) begin
				push_tick(1'($urandom_range(0, 1)), longint'($signed($urandom)), rand64(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				// samples with no reload, output may be invalid
				repeat ($urandom_range(2, 5)) begin
					gen_price = pick_price(gen_price);
					gen_ts = (gen_ts + pick_dt(tau_ms)) & MASK48;
					push_tick(OP_PRICE, gen_price, gen_ts, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	// Alternate a small and an extreme price with no decay to drive the sum far out
	task automatic pump_run(bit upward);
		logic [63:0] ts;
		longint      peak;
		peak = upward ? RET_TOP : RET_BOTTOM;
		ts = rand64() & MASK48;
		push_tick(OP_VALIDITY, 0, ts, 1'b0, 1'b0);
		push_tick(OP_PRICE, 1, ts, 1'b0, 1'b0);
		repeat (PUMP_PAIRS) begin
			ts = (ts + $urandom_range(0, 3)) & MASK48;
			push_tick(OP_PRICE, peak, ts, 1'b0, 1'b1);
			ts = (ts + $urandom_range(0, 3)) & MASK48;
			push_tick(OP_PRICE, 1, ts, 1'b1, 1'b0);
		end
	endtask

	// Sender: present the next transaction after its drawn gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (tick_taken) begin
				tick_taken = 1'b0;
				tick_on_bus = 1'b0;
				if ($urandom_range(0, 29) == 0)
					send_burst = !send_burst;
				send_gap = idle_cycles(send_burst);
			end
			if (!tick_on_bus) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (tick_queue.size() != 0) begin
					next_tick = tick_queue.pop_front();
					tick_on_bus = 1'b1;
					sample_ch.operation <= next_tick.operation;
					sample_ch.mid_price <= next_tick.mid_price;
					sample_ch.timestamp_ms <= next_tick.timestamp_ms;
					sample_ch.valid_flag <= next_tick.valid_flag;
					sample_ch.source_valid <= next_tick.source_valid;
				end
			end
			sample_ch.valid <= tick_on_bus;
		end
	end

	// Receiver: stall for a drawn number of cycles after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (signal_taken) begin
				signal_taken = 1'b0;
				if ($urandom_range(0, 29) == 0)
					recv_burst = !recv_burst;
				recv_stall = idle_cycles(recv_burst);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			result_ch.ready <= (recv_stall == 0);
		end
	end

	// Predict on accepted input, compare accepted results in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				tick_taken = 1'b1;
				bus_tick.operation = sample_ch.operation;
				bus_tick.mid_price = sample_ch.mid_price;
				bus_tick.timestamp_ms = sample_ch.timestamp_ms;
				bus_tick.valid_flag = sample_ch.valid_flag;
				bus_tick.source_valid = sample_ch.source_valid;
				step_shadow(bus_tick, predicted);
				awaited_signal.push_back(predicted);
			end
			if (result_ch.valid && result_ch.ready) begin
				signal_taken = 1'b1;
				got.signal_value = result_ch.signal_value;
				got.signal_valid = result_ch.signal_valid;
				got.value_written = result_ch.value_written;
				if (awaited_signal.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: result with none awaited: value %h valid %b written %b",
							$time, got.signal_value, got.signal_valid, got.value_written);
				end else begin
					want = awaited_signal.pop_front();
					if (got.signal_value !== want.signal_value ||
						got.signal_valid !== want.signal_valid ||
						got.value_written !== want.value_written) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display("%0t: expected value %h valid %b written %b, got %h %b %b",
								$time, want.signal_value, want.signal_valid, want.value_written,
								got.signal_value, got.signal_valid, got.value_written);
					end
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.operation = OP_PRICE;
		sample_ch.mid_price = '0;
		sample_ch.timestamp_ms = '0;
		sample_ch.valid_flag = 1'b0;
		sample_ch.source_valid = 1'b0;
		result_ch.ready = 1'b0;
		held_price = 0;
		held_time = '0;
		acc_q24 = 0;
		acc_valid = 1'b0;
		tau_ms = TAU_RESET;
		gen_price = 1000;
		gen_ts = 0;
		fault_count = 0;
		ticks_queued = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed transactions at the reset time constant
		push_tick(OP_PRICE, 1000, 100, 1'b0, 1'b0);       // first price only stored
		push_tick(OP_PRICE, 1100, 100, 1'b1, 1'b1);       // no elapsed time
		push_tick(OP_PRICE, 1100, 50, 1'b0, 1'b1);        // time going backwards
		push_tick(OP_PRICE, RET_TOP, 600, 1'b1, 1'b0);    // return saturates high
		push_tick(OP_PRICE, RET_BOTTOM, 1600, 1'b0, 1'b0); // large negative return, no saturation
		push_tick(OP_PRICE, 1, 2000, 1'b0, 1'b0);
		push_tick(OP_PRICE, -1, 2000, 1'b0, 1'b0);
		push_tick(OP_PRICE, 0, 3000, 1'b0, 1'b0);         // zero price is stored
		push_tick(OP_PRICE, 500, 4000, 1'b0, 1'b0);       // so this one is only stored
		push_tick(OP_PRICE, 510, 20000, 1'b0, 1'b0);      // exactly sixteen tau
		push_tick(OP_PRICE, 520, 36001, 1'b0, 1'b0);      // just past sixteen tau
		push_tick(OP_PRICE, 530, MASK48, 1'b1, 1'b1);     // latest timestamp
		push_tick(OP_PRICE, 531, 0, 1'b0, 1'b0);
		push_tick(OP_VALIDITY, 77, 5, 1'b1, 1'b0);        // valid event, source invalid
		push_tick(OP_VALIDITY, 7, 5, 1'b1, 1'b1);         // reload, output valid
		push_tick(OP_PRICE, 8, 700, 1'b1, 1'b1);          // fractional decay
		push_tick(OP_PRICE, -8, 1234, 1'b0, 1'b1);
		push_tick(OP_VALIDITY, -5, MASK48, 1'b0, 1'b1);   // invalid event clears
		push_tick(OP_PRICE, -300, 10, 1'b0, 1'b0);        // only stored after the clear
		push_tick(OP_PRICE, -200, 10, 1'b0, 1'b0);
		push_tick(OP_PRICE, 2000000000, 900, 1'b1, 1'b0);

		// Random phases over a spread of time constants
		write_tau(32'd1);
		random_phase(20);
		write_tau(32'hFFFF_FFFF);
		pump_run(1'($urandom_range(0, 1)));
		random_phase(20);
		write_tau(32'd0);
		random_phase(15);
		write_tau($urandom);
		random_phase(20);
		write_tau($urandom_range(2, 5000));
		random_phase(15);
		drain();
		random_phase(15);
		write_tau(TAU_RESET);
		random_phase(20);
		write_tau($urandom_range(1, 64));
		random_phase(20);
		write_tau({8'($urandom_range(1, 255)), 24'd0});
		random_phase(20);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fault_count += awaited_signal.size();
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
src/dra_pkg.sv
src/dra_if.sv
src/dra_sdiv.sv
src/decayed_return_accumulator_top.sv
tb/decayed_return_accumulator_top_test.sv
